// ===== rtl/bernstein_basis_deg10_eval_assert.svh =====
// Assertion macros shared by the Bernstein basis evaluator RTL.
`ifndef BERNSTEIN_BASIS_DEG10_EVAL_ASSERT_SVH
`define BERNSTEIN_BASIS_DEG10_EVAL_ASSERT_SVH
`ifndef SYNTHESIS
`define BBE_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("bbe: same-cycle check failed");
`define BBE_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("bbe: next-cycle check failed");
`else
`define BBE_ASSERT_IMP(lbl, pre, post)
`define BBE_ASSERT_NXT(lbl, pre, post)
`endif
`endif

// ===== rtl/bbe_pkg.sv =====
// Shared constants, tables and helpers for the Bernstein basis evaluator.
`timescale 1ns / 1ps
package bbe_pkg;
  localparam int DEGREE    = 10;
  localparam int TS_W      = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int IDX_W     = 4;
  localparam int VAL_W     = 31;
  localparam int DER_W     = 48;
  localparam int Q_W       = 31;

  localparam logic [CFG_IDX_W-1:0] REG_START_TIME   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INVERSE_SPAN = 2'd1;

  localparam logic [Q_W-1:0]   ONE30    = 31'h4000_0000;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEGREE);

  // Q1.30 product, rounded half up.
  function automatic logic [Q_W-1:0] qmul30(input logic [Q_W-1:0] a, input logic [Q_W-1:0] b);
    logic [2*Q_W-1:0] p;
    p = 62'(a) * 62'(b) + 62'h2000_0000;
    return p[60:30];
  endfunction

  function automatic logic [7:0] binom10(input logic [IDX_W-1:0] i);
    logic [7:0] c;
    case (i)
      4'd0, 4'd10: c = 8'd1;
      4'd1, 4'd9:  c = 8'd10;
      4'd2, 4'd8:  c = 8'd45;
      4'd3, 4'd7:  c = 8'd120;
      4'd4, 4'd6:  c = 8'd210;
      4'd5:        c = 8'd252;
      default:     c = 8'd0;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] binom9(input logic [IDX_W-1:0] i);
    logic [7:0] c;
    case (i)
      4'd0, 4'd9: c = 8'd1;
      4'd1, 4'd8: c = 8'd9;
      4'd2, 4'd7: c = 8'd36;
      4'd3, 4'd6: c = 8'd84;
      4'd4, 4'd5: c = 8'd126;
      default:    c = 8'd0;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] binom8(input logic [IDX_W-1:0] i);
    logic [7:0] c;
    case (i)
      4'd0, 4'd8: c = 8'd1;
      4'd1, 4'd7: c = 8'd8;
      4'd2, 4'd6: c = 8'd28;
      4'd3, 4'd5: c = 8'd56;
      4'd4:       c = 8'd70;
      default:    c = 8'd0;
    endcase
    return c;
  endfunction
endpackage

// ===== rtl/bbe_if.sv =====
// Valid/ready channel interfaces for time samples and basis results.
`timescale 1ns / 1ps
interface bbe_in_if import bbe_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [TS_W-1:0] time_sample;

  modport source (output valid, output time_sample, input ready);
  modport sink (input valid, input time_sample, output ready);
endinterface

interface bbe_out_if import bbe_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        basis_index;
  logic [VAL_W-1:0]        basis_value;
  logic signed [DER_W-1:0] first_derivative;
  logic signed [DER_W-1:0] second_derivative;
  logic                    clamped;
  logic                    last_of_sample;

  modport source (output valid, output basis_index, output basis_value,
                  output first_derivative, output second_derivative,
                  output clamped, output last_of_sample, input ready);
  modport sink (input valid, input basis_index, input basis_value,
                input first_derivative, input second_derivative,
                input clamped, input last_of_sample, output ready);
endinterface

// ===== rtl/bernstein_basis_deg10_eval.sv =====
// Degree-10 Bernstein basis evaluator with first and second time derivatives.
//
//   channel | dir | transfer when         | payload
//   in_ch   | in  | in_ch.valid & ready   | time_sample
//   out_ch  | out | out_ch.valid & ready  | index, value, two derivatives, flags
//   cfg_*   | in  | cfg_we                | cfg_index selects, cfg_wdata
//
// Each sample yields 11 results, one per cycle unless the output stalls, from the
// expander that walks the basis indices; it loads the next sample as the last
// index leaves. Path: difference and scaling registers, power stages, expander, back pipeline.
// Synchronous active-low reset clears valid bits and start_r, and sets inv_r to 32'h0001_0000.
// A stall at the output freezes the back pipeline; the front keeps filling until
// its last stage is full, then in_ch.ready drops.
`timescale 1ns / 1ps
`include "bernstein_basis_deg10_eval_assert.svh"
module bernstein_basis_deg10_eval import bbe_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  bbe_in_if.sink               in_ch,
  bbe_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  typedef struct packed {
    logic                      v;
    logic                      clamped;
    logic [DEGREE:0][Q_W-1:0]  tp;
    logic [DEGREE:0][Q_W-1:0]  up;
  } pw_stage_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] val;
    logic             clamped;
    logic             last;
  } tag_t;

  // Configuration.
  logic [CFG_W-1:0]   start_r, inv_r;
  logic [2*CFG_W-1:0] invsq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      inv_r   <= 32'h0001_0000;
    end else if (cfg_we) begin
      if (cfg_index == REG_START_TIME) begin
        start_r <= cfg_wdata;
      end else if (cfg_index == REG_INVERSE_SPAN) begin
        inv_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    invsq_r <= 64'(inv_r) * 64'(inv_r);
  end

  // Front pipeline: difference, scaling, clamp, then one power per stage.
  logic        front_en, back_en, xp_free, xp_load, xp_last;
  logic        f1_v_r, f2_v_r, f2_neg_r;
  logic [32:0] f1_diff_r;
  logic [63:0] f2_prod_r;
  logic [32:0] mag33;
  logic [32:0] t32;
  logic [33:0] t_sum;
  logic        t_clamp;
  logic [Q_W-1:0] t30;
  pw_stage_t   pw_r   [DEGREE];
  pw_stage_t   pw_nxt [DEGREE];

  assign in_ch.ready = front_en;
  assign mag33 = f1_diff_r[32] ? (33'd0 - f1_diff_r) : f1_diff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
      for (int s = 0; s < DEGREE; s++) begin
        pw_r[s].v <= 1'b0;
      end
    end else if (front_en) begin
      f1_v_r <= in_ch.valid;
      f2_v_r <= f1_v_r;
      pw_r   <= pw_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (front_en) begin
      f1_diff_r <= {in_ch.time_sample[TS_W-1], in_ch.time_sample} - {start_r[CFG_W-1], start_r};
      f2_neg_r  <= f1_diff_r[32];
      f2_prod_r <= 64'(mag33[31:0]) * 64'(inv_r);
    end
  end

  always_comb begin
    if (f2_neg_r && f2_prod_r != '0) begin
      t32     = '0;
      t_clamp = 1'b1;
    end else if (f2_prod_r > 64'h1_0000_0000) begin
      t32     = 33'h1_0000_0000;
      t_clamp = 1'b1;
    end else begin
      t32     = f2_prod_r[32:0];
      t_clamp = 1'b0;
    end
    t_sum = {1'b0, t32} + 34'd2;
    t30   = t_sum[32:2];

    pw_nxt[0]         = '0;
    pw_nxt[0].v       = f2_v_r;
    pw_nxt[0].clamped = t_clamp;
    pw_nxt[0].tp[0]   = ONE30;
    pw_nxt[0].tp[1]   = t30;
    pw_nxt[0].up[0]   = ONE30;
    pw_nxt[0].up[1]   = ONE30 - t30;
    for (int s = 1; s < DEGREE; s++) begin
      pw_nxt[s]          = pw_r[s-1];
      pw_nxt[s].tp[s+1]  = qmul30(pw_r[s-1].tp[s], pw_r[s-1].tp[1]);
      pw_nxt[s].up[s+1]  = qmul30(pw_r[s-1].up[s], pw_r[s-1].up[1]);
    end
  end

  // Expander: walks i = 0..10. tline_r[0] is t^i, uwin_r[k] is u^(10-i-k).
  logic                     xp_v_r, xp_clamped_r;
  logic [IDX_W-1:0]         xp_idx_r;
  logic [DEGREE:0][Q_W-1:0] tline_r, uwin_r;
  logic [Q_W-1:0]           tprev1_r, tprev2_r;

  assign xp_last  = xp_idx_r == LAST_IDX;
  assign xp_free  = !xp_v_r || (xp_last && back_en);
  assign xp_load  = xp_free && pw_r[DEGREE-1].v;
  assign front_en = !pw_r[DEGREE-1].v || xp_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xp_v_r <= 1'b0;
    end else if (back_en && xp_v_r && !xp_last) begin
      xp_idx_r <= xp_idx_r + 1'b1;
      tprev1_r <= tline_r[0];
      tprev2_r <= tprev1_r;
      for (int k = 0; k < DEGREE; k++) begin
        tline_r[k] <= tline_r[k+1];
        uwin_r[k]  <= uwin_r[k+1];
      end
      tline_r[DEGREE] <= '0;
      uwin_r[DEGREE]  <= '0;
    end else if (xp_free) begin
      xp_v_r <= pw_r[DEGREE-1].v;
      if (xp_load) begin
        xp_idx_r     <= '0;
        xp_clamped_r <= pw_r[DEGREE-1].clamped;
        tprev1_r     <= '0;
        tprev2_r     <= '0;
        tline_r      <= pw_r[DEGREE-1].tp;
        for (int k = 0; k <= DEGREE; k++) begin
          uwin_r[k] <= pw_r[DEGREE-1].up[DEGREE-k];
        end
      end
    end
  end

  // Back pipeline: products, binomial weights, differences, scaling, saturation.
  logic           b1_v_r, b2_v_r, b3_v_r, b4_v_r, b5_v_r, out_v_r;
  tag_t           b1_tag_r, b2_tag_r, b3_tag_r, b4_tag_r, b5_tag_r;
  logic [Q_W-1:0] p_val_r, p_a_r, p_b_r, p_c0_r, p_c1_r, p_c2_r;
  logic [37:0]    b2_a_r, b2_b_r, b2_c0_r, b2_c1_r, b2_c2_r;
  logic [38:0]    val_prod;
  logic           b3_neg1_r, b3_neg2_r, b4_neg1_r, b4_neg2_r, b5_neg1_r, b5_neg2_r;
  logic [41:0]    b3_m1_r;
  logic [45:0]    b3_m2_r;
  logic [52:0]    pp1l_r, pp1h_r;
  logic [54:0]    pp2ll_r, pp2lh_r, pp2hl_r, pp2hh_r;
  logic [52:0]    b5_q1_r;
  logic [72:0]    b5_q2_r;
  logic signed [39:0] ab;
  logic signed [43:0] d1;
  logic signed [41:0] cs;
  logic signed [48:0] d2;
  logic [74:0]    s1;
  logic [110:0]   s2;
  logic [IDX_W-1:0]        out_idx_r;
  logic [VAL_W-1:0]        out_val_r;
  logic [DER_W-1:0]        out_d1_r, out_d2_r;
  logic                    out_clamped_r, out_last_r;

  assign back_en = !out_v_r || out_ch.ready;

  function automatic logic [DER_W-1:0] sat48(input logic neg, input logic [72:0] q);
    logic [72:0]      limit;
    logic [72:0]      qs;
    logic [DER_W-1:0] r;
    limit = neg ? 73'h8000_0000_0000 : 73'h7FFF_FFFF_FFFF;
    qs    = (q > limit) ? limit : q;
    r     = qs[DER_W-1:0];
    return neg ? (48'd0 - r) : r;
  endfunction

  always_comb begin
    val_prod = 39'(binom10(b1_tag_r.idx)) * 39'(p_val_r);
    ab = $signed({2'b0, b2_a_r}) - $signed({2'b0, b2_b_r});
    d1 = 44'(ab) * 44'sd10;
    cs = $signed({4'b0, b2_c0_r}) - $signed({3'b0, b2_c1_r, 1'b0}) + $signed({4'b0, b2_c2_r});
    d2 = 49'(cs) * 49'sd90;
    s1 = (75'(pp1h_r) << 21) + 75'(pp1l_r) + (75'(1) << 21);
    s2 = (111'(pp2hh_r) << 55) + (111'(pp2hl_r) << 23) + (111'(pp2lh_r) << 32)
       + 111'(pp2ll_r) + (111'(1) << 37);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r  <= 1'b0;
      b2_v_r  <= 1'b0;
      b3_v_r  <= 1'b0;
      b4_v_r  <= 1'b0;
      b5_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (back_en) begin
      b1_v_r  <= xp_v_r;
      b2_v_r  <= b1_v_r;
      b3_v_r  <= b2_v_r;
      b4_v_r  <= b3_v_r;
      b5_v_r  <= b4_v_r;
      out_v_r <= b5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (back_en) begin
      // Out-of-range neighbors read as zero words, so their products vanish.
      b1_tag_r.idx     <= xp_idx_r;
      b1_tag_r.val     <= '0;
      b1_tag_r.clamped <= xp_clamped_r;
      b1_tag_r.last    <= xp_last;
      p_val_r <= qmul30(tline_r[0], uwin_r[0]);
      p_a_r   <= qmul30(tprev1_r, uwin_r[0]);
      p_b_r   <= qmul30(tline_r[0], uwin_r[1]);
      p_c0_r  <= qmul30(tprev2_r, uwin_r[0]);
      p_c1_r  <= qmul30(tprev1_r, uwin_r[1]);
      p_c2_r  <= qmul30(tline_r[0], uwin_r[2]);

      b2_tag_r.idx     <= b1_tag_r.idx;
      b2_tag_r.clamped <= b1_tag_r.clamped;
      b2_tag_r.last    <= b1_tag_r.last;
      b2_tag_r.val     <= (val_prod > 39'(ONE30)) ? ONE30 : val_prod[VAL_W-1:0];
      b2_a_r  <= 38'(39'(binom9(IDX_W'(b1_tag_r.idx - 1'b1))) * 39'(p_a_r));
      b2_b_r  <= 38'(39'(binom9(b1_tag_r.idx)) * 39'(p_b_r));
      b2_c0_r <= 38'(39'(binom8(IDX_W'(b1_tag_r.idx - 2'd2))) * 39'(p_c0_r));
      b2_c1_r <= 38'(39'(binom8(IDX_W'(b1_tag_r.idx - 1'b1))) * 39'(p_c1_r));
      b2_c2_r <= 38'(39'(binom8(b1_tag_r.idx)) * 39'(p_c2_r));

      b3_tag_r  <= b2_tag_r;
      b3_neg1_r <= d1[43];
      b3_m1_r   <= d1[43] ? 42'(44'sd0 - d1) : d1[41:0];
      b3_neg2_r <= d2[48];
      b3_m2_r   <= d2[48] ? 46'(49'sd0 - d2) : d2[45:0];

      b4_tag_r  <= b3_tag_r;
      b4_neg1_r <= b3_neg1_r;
      b4_neg2_r <= b3_neg2_r;
      pp1l_r    <= 53'(b3_m1_r[20:0]) * 53'(inv_r);
      pp1h_r    <= 53'(b3_m1_r[41:21]) * 53'(inv_r);
      pp2ll_r   <= 55'(b3_m2_r[22:0]) * 55'(invsq_r[31:0]);
      pp2lh_r   <= 55'(b3_m2_r[22:0]) * 55'(invsq_r[63:32]);
      pp2hl_r   <= 55'(b3_m2_r[45:23]) * 55'(invsq_r[31:0]);
      pp2hh_r   <= 55'(b3_m2_r[45:23]) * 55'(invsq_r[63:32]);

      b5_tag_r  <= b4_tag_r;
      b5_neg1_r <= b4_neg1_r;
      b5_neg2_r <= b4_neg2_r;
      b5_q1_r   <= s1[74:22];
      b5_q2_r   <= s2[110:38];

      out_idx_r     <= b5_tag_r.idx;
      out_val_r     <= b5_tag_r.val;
      out_clamped_r <= b5_tag_r.clamped;
      out_last_r    <= b5_tag_r.last;
      out_d1_r      <= sat48(b5_neg1_r, 73'(b5_q1_r));
      out_d2_r      <= sat48(b5_neg2_r, b5_q2_r);
    end
  end

  assign out_ch.valid             = out_v_r;
  assign out_ch.basis_index       = out_idx_r;
  assign out_ch.basis_value       = out_val_r;
  assign out_ch.first_derivative  = out_d1_r;
  assign out_ch.second_derivative = out_d2_r;
  assign out_ch.clamped           = out_clamped_r;
  assign out_ch.last_of_sample    = out_last_r;

  `BBE_ASSERT_IMP(a_xp_idx_range, xp_v_r, xp_idx_r <= LAST_IDX)
  `BBE_ASSERT_IMP(a_out_last_idx, out_v_r, out_last_r == (out_idx_r == LAST_IDX))
  `BBE_ASSERT_IMP(a_out_val_cap, out_v_r, out_val_r <= ONE30)
  `BBE_ASSERT_NXT(a_front_hold, pw_r[DEGREE-1].v && !front_en, pw_r[DEGREE-1].v && $stable(pw_r[DEGREE-1].tp))
  `BBE_ASSERT_NXT(a_xp_step, xp_v_r && !xp_last && back_en, xp_v_r && xp_idx_r == $past(xp_idx_r) + 1'b1)

endmodule

// ===== tb/sv/bernstein_basis_deg10_eval_test.sv =====
// Testbench for the degree-10 Bernstein basis evaluator with time derivatives.
`timescale 1ns / 1ps
module bernstein_basis_deg10_eval_test;
  import bbe_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0]        basis_index;
    logic [VAL_W-1:0]        basis_value;
    logic signed [DER_W-1:0] first_derivative;
    logic signed [DER_W-1:0] second_derivative;
    logic                    clamped;
    logic                    last_of_sample;
  } basis_result_t;

  typedef struct {
    logic                   is_cfg;
    logic [CFG_IDX_W-1:0]   reg_index;
    logic [31:0]            value;
    logic                   has_typed;
    logic [VAL_W-1:0]       typed_value0;
    logic                   typed_clamped;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic out_ready_q = 1'b0;

  bbe_in_if in_ch ();
  bbe_out_if out_ch ();

  bernstein_basis_deg10_eval u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.time_sample = '0;
  end
  assign out_ch.ready = out_ready_q;

  // Predictor's own copy of the registers.
  logic signed [31:0] pred_start;
  logic [31:0] pred_inv_span;
  basis_result_t expected_results[$];
  int fail_count = 0;
  int idle_cycles = 0;
  bit drain_mode = 0;

  function automatic logic [Q_W-1:0] mul_q30(logic [Q_W-1:0] a, logic [Q_W-1:0] b);
    logic [63:0] p;
    p = 64'(a) * 64'(b) + 64'd536870912;
    return p[60:30];
  endfunction

  // Magnitude of v times k, shifted right by s with half-away rounding, saturated.
  function automatic logic [DER_W-1:0] scale_derivative(longint v, logic [63:0] k, int s);
    logic [63:0] mag;
    logic [127:0] prod;
    logic [127:0] q;
    logic [63:0] lim;
    mag = (v < 0) ? 64'(-v) : 64'(v);
    lim = (v < 0) ? 64'h8000_0000_0000 : 64'h7FFF_FFFF_FFFF;
    prod = 128'(mag) * 128'(k) + (128'd1 << (s - 1));
    q = prod >> s;
    if (q > 128'(lim)) q = 128'(lim);
    return (v < 0) ? DER_W'(-q[63:0]) : DER_W'(q[63:0]);
  endfunction

  task automatic predict_basis_set(logic signed [31:0] ts);
    longint diff;
    logic [63:0] mag, prod, t32, inv, inv2;
    logic [Q_W-1:0] t30, u30;
    logic [Q_W-1:0] tpow[0:DEGREE];
    logic [Q_W-1:0] upow[0:DEGREE];
    longint b9[0:DEGREE-1];
    longint b8[0:DEGREE-2];
    longint a, b, c0, c1, c2;
    logic [63:0] val;
    logic clamp_flag;
    basis_result_t r;
    clamp_flag = 1'b0;
    diff = longint'(ts) - longint'(pred_start);
    inv = 64'(pred_inv_span);
    inv2 = inv * inv;
    mag = (diff < 0) ? 64'(-diff) : 64'(diff);
    prod = mag * inv;
    if (diff < 0 && prod != 0) begin
      t32 = 0;
      clamp_flag = 1'b1;
    end else if (prod > 64'h1_0000_0000) begin
      t32 = 64'h1_0000_0000;
      clamp_flag = 1'b1;
    end else begin
      t32 = prod;
    end
    t30 = Q_W'((t32 + 2) >> 2);
    u30 = ONE30 - t30;
    tpow[0] = ONE30;
    upow[0] = ONE30;
    for (int i = 1; i <= DEGREE; i++) begin
      tpow[i] = mul_q30(tpow[i-1], t30);
      upow[i] = mul_q30(upow[i-1], u30);
    end
    for (int i = 0; i < DEGREE; i++)
      b9[i] = longint'(binom9(IDX_W'(i))) * longint'(mul_q30(tpow[i], upow[DEGREE-1-i]));
    for (int i = 0; i < DEGREE - 1; i++)
      b8[i] = longint'(binom8(IDX_W'(i))) * longint'(mul_q30(tpow[i], upow[DEGREE-2-i]));
    for (int i = 0; i <= DEGREE; i++) begin
      val = 64'(binom10(IDX_W'(i))) * 64'(mul_q30(tpow[i], upow[DEGREE-i]));
      if (val > 64'(ONE30)) val = 64'(ONE30);
      a = (i >= 1) ? b9[i-1] : 0;
      b = (i <= DEGREE - 1) ? b9[i] : 0;
      c0 = (i >= 2) ? b8[i-2] : 0;
      c1 = (i >= 1 && i - 1 <= DEGREE - 2) ? b8[i-1] : 0;
      c2 = (i <= DEGREE - 2) ? b8[i] : 0;
      r.basis_index = IDX_W'(i);
      r.basis_value = VAL_W'(val);
      r.first_derivative = scale_derivative(10 * (a - b), inv, 22);
      r.second_derivative = scale_derivative(90 * (c0 - 2 * c1 + c2), inv2, 38);
      r.clamped = clamp_flag;
      r.last_of_sample = (i == DEGREE);
      expected_results.push_back(r);
    end
  endtask

  task automatic report_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Result checker and receiver stall pattern.
  always @(posedge clk) begin
    basis_result_t e;
    if (rst_n && out_ch.valid && out_ready_q) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result transfer, index %0d", $time, out_ch.basis_index);
        fail_count++;
      end else begin
        e = expected_results.pop_front();
        report_field("basis_index", e.basis_index, out_ch.basis_index);
        report_field("basis_value", e.basis_value, out_ch.basis_value);
        report_field("first_derivative", e.first_derivative, out_ch.first_derivative);
        report_field("second_derivative", e.second_derivative, out_ch.second_derivative);
        report_field("clamped", e.clamped, out_ch.clamped);
        report_field("last_of_sample", e.last_of_sample, out_ch.last_of_sample);
      end
    end
    if (drain_mode || (($time / 400) % 3 == 0)) out_ready_q <= 1'b1;
    else out_ready_q <= ($urandom_range(0, 3) != 0);
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_START_TIME) pred_start = value;
    else if (idx == REG_INVERSE_SPAN) pred_inv_span = value;
  endtask

  // Holds one sample on the channel until it transfers.
  task automatic send_sample(logic signed [31:0] ts);
    in_ch.valid <= 1'b1;
    in_ch.time_sample <= ts;
    do @(posedge clk); while (!in_ch.ready);
    predict_basis_set(ts);
  endtask

  // Drops valid at once so the last sample cannot transfer a second time.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    drain_mode = 1;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    drain_mode = 0;
  endtask

  task automatic random_burst_phase(int n_samples, bit wide);
    int burst;
    int gap;
    logic signed [31:0] ts;
    burst = 0;
    for (int k = 0; k < n_samples; k++) begin
      if (burst == 0) begin
        gap = $urandom_range(0, 25);
        if (gap > 0) begin
          in_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst = $urandom_range(1, 8);
      end
      if (wide || $urandom_range(0, 4) == 0) ts = $urandom;
      else ts = pred_start + $signed($urandom_range(0, 131072)) - 32'sd8192;
      send_sample(ts);
      burst--;
    end
  endtask

  stim_row_t directed_rows[$];
  basis_result_t first_of_set;

  task automatic add_sample_row(logic [31:0] ts, logic typed, logic [VAL_W-1:0] v0,
                                logic clamp_flag);
    stim_row_t r;
    r = '{1'b0, REG_START_TIME, ts, typed, v0, clamp_flag};
    directed_rows.push_back(r);
  endtask

  task automatic add_cfg_row(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    stim_row_t r;
    r = '{1'b1, idx, value, 1'b0, '0, 1'b0};
    directed_rows.push_back(r);
  endtask

  initial begin
    pred_start = 0;
    pred_inv_span = 32'h0001_0000;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // After reset t is the sample divided by 2^16; index 0 is 1.0 at t=0 and 0 at t=1.
    add_sample_row(32'h0000_0000, 1, ONE30, 0);
    add_sample_row(32'h0001_0000, 1, '0, 0);
    add_sample_row(32'h0000_8000, 0, '0, 0);
    add_sample_row(32'h8000_0000, 1, ONE30, 1);
    add_sample_row(32'h7FFF_FFFF, 1, '0, 1);
    add_sample_row(32'hFFFF_FFFF, 1, ONE30, 1);
    add_sample_row(32'h0001_0001, 1, '0, 1);
    add_cfg_row(REG_START_TIME, 32'h8000_0000);
    add_cfg_row(REG_INVERSE_SPAN, 32'h0000_0001);
    add_sample_row(32'h7FFF_FFFF, 0, '0, 0);
    add_sample_row(32'h8000_0000, 1, ONE30, 0);
    add_cfg_row(REG_INVERSE_SPAN, 32'h0000_0000);
    add_sample_row(32'h7FFF_FFFF, 1, ONE30, 0);
    add_cfg_row(REG_START_TIME, 32'h7FFF_FFFF);
    add_cfg_row(REG_INVERSE_SPAN, 32'hFFFF_FFFF);
    add_sample_row(32'h7FFF_FFFF, 1, ONE30, 0);
    add_sample_row(32'h8000_0000, 1, ONE30, 1);
    add_cfg_row(REG_START_TIME, 32'h0000_0000);
    add_cfg_row(REG_INVERSE_SPAN, 32'h0100_0000);
    add_sample_row(32'h0000_0080, 0, '0, 0);
    add_sample_row(32'h0000_0100, 1, '0, 0);
    // Out-of-range index must leave both registers unchanged.
    add_cfg_row(2'd3, 32'h1234_5678);
    add_sample_row(32'h0000_0040, 0, '0, 0);

    foreach (directed_rows[k]) begin
      if (directed_rows[k].is_cfg) begin
        drain_results();
        write_register(directed_rows[k].reg_index, directed_rows[k].value);
      end else begin
        send_sample(directed_rows[k].value);
        first_of_set = expected_results[expected_results.size() - 11];
        if (directed_rows[k].has_typed &&
            (first_of_set.basis_value !== directed_rows[k].typed_value0 ||
             first_of_set.clamped !== directed_rows[k].typed_clamped)) begin
          $display("%0t: typed row %0d: expected value %h clamp %b, predicted %h clamp %b",
                   $time, k, directed_rows[k].typed_value0, directed_rows[k].typed_clamped,
                   first_of_set.basis_value, first_of_set.clamped);
          fail_count++;
        end
      end
    end
    drain_results();

    // Random phases over several register settings.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_register(REG_START_TIME, $urandom);
          write_register(REG_INVERSE_SPAN, $urandom_range(32'h4000, 32'h40000));
        end
        1: write_register(REG_INVERSE_SPAN, $urandom);
        2: write_register(REG_INVERSE_SPAN, 32'hFFFF_FFFF);
        3: begin
          write_register(REG_START_TIME, 32'h8000_0000);
          write_register(REG_INVERSE_SPAN, $urandom_range(1, 16));
        end
        4: write_register(REG_INVERSE_SPAN, 32'h0000_0000);
        default: begin
          write_register(REG_START_TIME, $urandom);
          write_register(REG_INVERSE_SPAN, $urandom_range(32'h100, 32'h0100_0000));
        end
      endcase
      random_burst_phase(ph == 4 ? 15 : 49, ph == 4);
      drain_results();
    end

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
